>>> src/gslpf_pkg.sv
// shared types, constants and the peak test for the local peak finder
package gslpf_pkg;

    localparam int COORD_W     = 11;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_VALUE_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS   = 2'd0,
        CFG_NUM_COLS   = 2'd1,
        CFG_TARGET_ROW = 2'd2,
        CFG_TARGET_COL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] num_rows;
        logic [CFG_W-1:0] num_cols;
        logic [CFG_W-1:0] target_row;
        logic [CFG_W-1:0] target_col;
    } t_cfg;

    // pend bits 0..3 are the four window checks in emit order, bit 4 the verdict
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [4:0]         pend;
        logic               hit;
    } t_rec;

    typedef logic signed [31:0] t_val;
    typedef t_val t_win [9];

    // center strictly above every in-grid neighbour; rv/cv mark window rows/cols inside the grid
    function automatic logic is_peak(t_win w, int ci, int cj, logic [2:0] rv, logic [2:0] cv);
        logic p;
        p = 1'b1;
        for (int wi = 0; wi < 3; wi++) begin
            for (int wj = 0; wj < 3; wj++) begin
                if (!(wi == ci && wj == cj) && wi >= ci - 1 && wi <= ci + 1 &&
                    wj >= cj - 1 && wj <= cj + 1 && rv[wi] && cv[wj] &&
                    w[wi*3+wj] >= w[ci*3+cj]) begin
                    p = 1'b0;
                end
            end
        end
        return p;
    endfunction

endpackage

>>> src/gslpf_front.sv
// front end: position tracking, line stores, 3x3 window and peak checks
module gslpf_front
    import gslpf_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_valid,
    input  logic signed [VALUE_BITS-1:0] i_cell_value,
    output logic                         o_stall,
    output logic                         o_push,
    output t_rec                         o_rec,
    input  logic                         i_full
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [VALUE_BITS-1:0] upper_line  [MAX_COLS];
    logic [VALUE_BITS-1:0] middle_line [MAX_COLS];

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          r_hit;

    logic                         r_s1_valid;
    logic signed [VALUE_BITS-1:0] r_x;
    logic [CW-1:0]                r_idx;
    logic [COORD_W-1:0]           r_rlo, r_clo;
    logic                         r_r1, r_r2, r_c1, r_c2, r_lrow, r_lcol;
    logic                         r_hr0, r_hr1, r_hc0, r_hc1;
    logic [VALUE_BITS-1:0]        r_up_q, r_mid_q;
    logic                         r_fwd;
    logic [VALUE_BITS-1:0]        r_fwd_up, r_fwd_mid;
    logic [VALUE_BITS-1:0]        r_win [6];

    logic        acc, s1_adv, s1_wr, need_push;
    logic [31:0] n_rows, n_cols, r32, c32, tr32, tc32;
    logic        lrow_a, lcol_a;
    logic [VALUE_BITS-1:0] up_eff, mid_eff;
    t_win        w;
    logic [3:0]  pk;
    logic        verdict, hit_now;

    always_comb begin
        n_rows = (i_cfg.num_rows == '0) ? 32'd1 :
                 ((32'(i_cfg.num_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(i_cfg.num_rows));
        n_cols = (i_cfg.num_cols == '0) ? 32'd1 :
                 ((32'(i_cfg.num_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(i_cfg.num_cols));
        r32    = 32'(r_row);
        c32    = 32'(r_col);
        tr32   = 32'(i_cfg.target_row);
        tc32   = 32'(i_cfg.target_col);
        lrow_a = r32 >= n_rows - 32'd1;
        lcol_a = c32 >= n_cols - 32'd1;
    end

    assign up_eff  = r_fwd ? r_fwd_up  : r_up_q;
    assign mid_eff = r_fwd ? r_fwd_mid : r_mid_q;

    always_comb begin
        w[0] = 32'($signed(r_win[3]));
        w[3] = 32'($signed(r_win[4]));
        w[6] = 32'($signed(r_win[5]));
        w[1] = 32'($signed(r_win[0]));
        w[4] = 32'($signed(r_win[1]));
        w[7] = 32'($signed(r_win[2]));
        w[2] = 32'($signed(up_eff));
        w[5] = 32'($signed(mid_eff));
        w[8] = 32'(r_x);
        pk[0] = r_r1 && r_c1 && is_peak(w, 1, 1, {1'b1, r_r1, r_r2}, {1'b1, r_c1, r_c2});
        pk[1] = r_lrow && r_c1 && is_peak(w, 2, 1, {1'b1, r_r1, r_r2}, {1'b1, r_c1, r_c2});
        pk[2] = r_r1 && r_lcol && is_peak(w, 1, 2, {1'b1, r_r1, r_r2}, {1'b1, r_c1, r_c2});
        pk[3] = r_lrow && r_lcol && is_peak(w, 2, 2, {1'b1, r_r1, r_r2}, {1'b1, r_c1, r_c2});
        verdict = r_lrow && r_lcol;
        hit_now = r_hit || (pk[0] && r_hr0 && r_hc0) || (pk[1] && r_hr1 && r_hc0) ||
                  (pk[2] && r_hr0 && r_hc1) || (pk[3] && r_hr1 && r_hc1);
    end

    assign need_push = (pk != 4'b0) || verdict;
    assign s1_adv    = !need_push || !i_full;
    assign s1_wr     = r_s1_valid && s1_adv;
    assign o_stall   = r_s1_valid && !s1_adv;
    assign acc       = i_valid && !o_stall;
    assign o_push    = s1_wr && need_push;

    always_comb begin
        o_rec.row  = r_rlo;
        o_rec.col  = r_clo;
        o_rec.pend = {verdict, pk};
        o_rec.hit  = hit_now;
    end

    // line stores: read when a word is taken, written when it leaves the window stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_up_q  <= upper_line[r_col];
            r_mid_q <= middle_line[r_col];
        end
        if (s1_wr) begin
            upper_line[r_idx]  <= mid_eff;
            middle_line[r_idx] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_x       <= i_cell_value;
            r_idx     <= r_col;
            r_rlo     <= COORD_W'(r_row);
            r_clo     <= COORD_W'(r_col);
            r_r1      <= r32 >= 32'd1;
            r_r2      <= r32 >= 32'd2;
            r_c1      <= c32 >= 32'd1;
            r_c2      <= c32 >= 32'd2;
            r_lrow    <= lrow_a;
            r_lcol    <= lcol_a;
            r_hr0     <= r32 == tr32;
            r_hr1     <= r32 + 32'd1 == tr32;
            r_hc0     <= c32 == tc32;
            r_hc1     <= c32 + 32'd1 == tc32;
            // the word in the window stage writes the same column this cycle
            r_fwd     <= s1_wr && (r_idx == r_col);
            r_fwd_up  <= mid_eff;
            r_fwd_mid <= r_x;
        end
        if (s1_wr) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= up_eff;
            r_win[1] <= mid_eff;
            r_win[2] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_hit      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                if (lcol_a) begin
                    r_col <= '0;
                    r_row <= lrow_a ? '0 : RW'(r32 + 32'd1);
                end else begin
                    r_col <= CW'(c32 + 32'd1);
                end
            end
            if (s1_wr) begin
                r_hit <= verdict ? 1'b0 : hit_now;
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && lrow_a && lcol_a |=> r_row == '0 && r_col == '0)
        else $error("position not cleared after frame end");

    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_s1_valid |-> s1_wr)
        else $error("word taken while the window stage holds its word");

endmodule

>>> src/gslpf_queue.sv
// small queue of result records between the window stage and the output side
module gslpf_queue
    import gslpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= QPTR_W'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= QPTR_W'(r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

>>> src/gslpf_back.sv
// back end: unpacks result records into words on the output register
module gslpf_back
    import gslpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_rec               i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [COORD_W-1:0] o_peak_row,
    output logic [COORD_W-1:0] o_peak_col,
    output logic               o_target_hit,
    output logic               o_last
);

    t_rec               r_rec;
    logic [4:0]         r_pend;
    logic               r_out_valid;
    logic               r_kind, r_hit, r_last;
    logic [COORD_W-1:0] r_prow, r_pcol;

    t_rec               cur;
    logic [4:0]         cur_pend, low, n_pend;
    logic               slot_free, emit;
    logic [COORD_W-1:0] row_p1, col_p1;

    always_comb begin
        o_pop     = (r_pend == '0) && !i_empty;
        cur       = o_pop ? i_rec : r_rec;
        cur_pend  = o_pop ? i_rec.pend : r_pend;
        low       = cur_pend & (~cur_pend + 5'd1);
        slot_free = !r_out_valid || !i_stall;
        emit      = slot_free && (cur_pend != '0);
        n_pend    = emit ? (cur_pend & ~low) : cur_pend;
        row_p1    = COORD_W'(cur.row + 1'b1);
        col_p1    = COORD_W'(cur.col + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (emit) begin
            r_kind <= low[4];
            r_last <= low[4];
            r_hit  <= low[4] && cur.hit;
            r_prow <= (low[1] || low[3]) ? row_p1 : (low[4] ? '0 : cur.row);
            r_pcol <= (low[2] || low[3]) ? col_p1 : (low[4] ? '0 : cur.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_peak_row   = r_prow;
    assign o_peak_col   = r_pcol;
    assign o_target_hit = r_hit;
    assign o_last       = r_last;

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && low[4] |-> cur_pend == 5'b10000)
        else $error("verdict emitted ahead of pending peaks");

endmodule

>>> src/grid_strict_local_peak_finder_top.sv
// Top level of the 3x3 strict local peak finder.
// A result passes from the window stage through the 4-entry result queue to the output register.
// Throughput: one cell per cycle while o_stall is low; the output side moves one result word per
// cycle while i_stall is low; the input stalls when a cell completes results and the queue is full.
// Reset is synchronous active low: counters, queue, output valid and config go to their reset
// values; the line stores are not cleared and need no clearing pass.
module grid_strict_local_peak_finder_top
    import gslpf_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [VALUE_BITS-1:0] i_cell_value,
    output logic                         o_stall,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic [COORD_W-1:0]           o_peak_row,
    output logic [COORD_W-1:0]           o_peak_col,
    output logic                         o_target_hit,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    t_cfg r_cfg;
    logic push, full, pop, empty;
    t_rec rec_in, rec_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_rows   <= CFG_W'(1);
            r_cfg.num_cols   <= CFG_W'(1);
            r_cfg.target_row <= CFG_W'(1);
            r_cfg.target_col <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_ROWS:   r_cfg.num_rows   <= i_cfg_data;
                CFG_NUM_COLS:   r_cfg.num_cols   <= i_cfg_data;
                CFG_TARGET_ROW: r_cfg.target_row <= i_cfg_data;
                CFG_TARGET_COL: r_cfg.target_col <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gslpf_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_cell_value (i_cell_value),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_rec        (rec_in),
        .i_full       (full)
    );

    gslpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rec   (rec_out)
    );

    gslpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_rec        (rec_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_peak_row   (o_peak_row),
        .o_peak_col   (o_peak_col),
        .o_target_hit (o_target_hit),
        .o_last       (o_last)
    );

endmodule

>>> sim/grid_strict_local_peak_finder_checker.sv
// checker for the local peak finder: watches both channels, predicts peaks and verdicts, compares
module grid_strict_local_peak_finder_checker
    import gslpf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_cell_value,
    input  logic                 i_stall_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_kind,
    input  logic [COORD_W-1:0]   i_peak_row,
    input  logic [COORD_W-1:0]   i_peak_col,
    input  logic                 i_target_hit,
    input  logic                 i_last,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN = 1024;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               hit;
        logic               last;
    } t_word;

    t_word       expected_words[$];
    logic [10:0] rows_reg, cols_reg, trow_reg, tcol_reg;
    logic signed [15:0] upper_mem[LINE_LEN];
    logic signed [15:0] middle_mem[LINE_LEN];
    logic signed [15:0] win_prev[6];
    int unsigned row_pos, col_pos;
    bit          target_seen;

    assign o_pending = expected_words.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic int unsigned fit_size(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    function automatic bit strict_max(input logic signed [15:0] w[3][3], input int ci,
                                      input int cj, input int unsigned r, input int unsigned c);
        for (int di = -1; di <= 1; di++)
            for (int dj = -1; dj <= 1; dj++) begin
                int wi, wj;
                wi = ci + di;
                wj = cj + dj;
                if (di == 0 && dj == 0) continue;
                if (wi < 0 || wi > 2 || wj < 0 || wj > 2) continue;
                if (wi + r < 2 || wj + c < 2) continue;
                if (w[wi][wj] >= w[ci][cj]) return 0;
            end
        return 1;
    endfunction

    task automatic test_cell(input logic signed [15:0] w[3][3], input int ci, input int cj,
                             input int unsigned r, input int unsigned c,
                             input int unsigned gr, input int unsigned gc);
        t_word e;
        if (!strict_max(w, ci, cj, r, c)) return;
        if (gr + 1 == trow_reg && gc + 1 == tcol_reg) target_seen = 1;
        e = '{kind: 1'b0, row: COORD_W'(gr + 1), col: COORD_W'(gc + 1), hit: 1'b0, last: 1'b0};
        expected_words.push_back(e);
    endtask

    task automatic predict_cell(input logic signed [15:0] x);
        int unsigned n, m, r, c, idx;
        bit lr, lc;
        logic signed [15:0] w[3][3];
        t_word e;
        n = fit_size(rows_reg);
        m = fit_size(cols_reg);
        r = row_pos;
        c = col_pos;
        idx = (c < LINE_LEN) ? c : LINE_LEN - 1;
        lr = r >= n - 1;
        lc = c >= m - 1;
        for (int i = 0; i < 3; i++) begin
            w[i][1] = win_prev[i];
            w[i][0] = win_prev[3+i];
        end
        w[0][2] = upper_mem[idx];
        w[1][2] = middle_mem[idx];
        w[2][2] = x;
        if (r >= 1 && c >= 1) test_cell(w, 1, 1, r, c, r - 1, c - 1);
        if (lr && c >= 1) test_cell(w, 2, 1, r, c, r, c - 1);
        if (r >= 1 && lc) test_cell(w, 1, 2, r, c, r - 1, c);
        if (lr && lc) test_cell(w, 2, 2, r, c, r, c);
        upper_mem[idx] = w[1][2];
        middle_mem[idx] = x;
        for (int i = 0; i < 3; i++) begin
            win_prev[3+i] = win_prev[i];
            win_prev[i] = w[i][2];
        end
        if (lc) begin
            col_pos = 0;
            if (lr) begin
                e = '{kind: 1'b1, row: '0, col: '0, hit: target_seen, last: 1'b1};
                expected_words.push_back(e);
                row_pos = 0;
                target_seen = 0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < LINE_LEN; i++) begin
            upper_mem[i] = '0;
            middle_mem[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_prev[i] = '0;
    end

    always @(posedge i_clk) begin
        t_word e;
        if (!i_rst_n) begin
            rows_reg <= 1; cols_reg <= 1; trow_reg <= 1; tcol_reg <= 1;
            row_pos = 0; col_pos = 0; target_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    e = expected_words.pop_front();
                    if (i_kind !== e.kind) report_mismatch($sformatf("kind %0b want %0b",
                        i_kind, e.kind));
                    if (i_peak_row !== e.row) report_mismatch($sformatf("row %0d want %0d",
                        i_peak_row, e.row));
                    if (i_peak_col !== e.col) report_mismatch($sformatf("col %0d want %0d",
                        i_peak_col, e.col));
                    if (i_target_hit !== e.hit) report_mismatch($sformatf("hit %0b want %0b",
                        i_target_hit, e.hit));
                    if (i_last !== e.last) report_mismatch($sformatf("last %0b want %0b",
                        i_last, e.last));
                end
            end
            if (i_valid && !i_stall_in) predict_cell(i_cell_value);
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_ROWS:   rows_reg <= i_cfg_data;
                    CFG_NUM_COLS:   cols_reg <= i_cfg_data;
                    CFG_TARGET_ROW: trow_reg <= i_cfg_data;
                    CFG_TARGET_COL: tcol_reg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> sim/grid_strict_local_peak_finder_top_tb.sv
// testbench top for the local peak finder: stimulus, stalls, watchdog and verdict
module grid_strict_local_peak_finder_top_tb;
    import gslpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                 clk, rst_n;
    logic                 cell_valid, out_stall;
    logic signed [15:0]   cell_value;
    logic                 in_stall, out_valid;
    logic                 kind, target_hit, last_flag;
    logic [COORD_W-1:0]   peak_row, peak_col;
    logic                 cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors, pending, idle_cycles;
    bit                   hold_out;

    grid_strict_local_peak_finder_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(cell_valid), .i_cell_value(cell_value),
        .o_stall(in_stall), .o_valid(out_valid), .i_stall(out_stall), .o_kind(kind),
        .o_peak_row(peak_row), .o_peak_col(peak_col), .o_target_hit(target_hit),
        .o_last(last_flag), .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    grid_strict_local_peak_finder_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(cell_valid), .i_cell_value(cell_value),
        .i_stall_in(in_stall), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_kind(kind), .i_peak_row(peak_row), .i_peak_col(peak_col),
        .i_target_hit(target_hit), .i_last(last_flag), .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall per word, plus one long hold-off on request
    initial begin
        out_stall = 1;
        forever begin
            int gap;
            @(negedge clk);
            if (hold_out) begin
                out_stall <= 1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (gap != 0) begin
                    out_stall <= 1;
                    repeat (gap) @(negedge clk);
                end
                out_stall <= 0;
                do @(posedge clk); while (!(out_valid && !out_stall));
                // the next negedge starts a new draw
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cell_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays up after the write; set_frame drops it after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic drain_out();
        cell_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_frame(input int r, input int c, input int tr, input int tc);
        drain_out();
        write_reg(CFG_NUM_ROWS, CFG_W'(r));
        write_reg(CFG_NUM_COLS, CFG_W'(c));
        write_reg(CFG_TARGET_ROW, CFG_W'(tr));
        write_reg(CFG_TARGET_COL, CFG_W'(tc));
        cfg_valid <= 0;
    endtask

    // valid stays up after the word is taken; a gap or drain_out drops it
    task automatic send_cell(input logic signed [15:0] v, input bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            cell_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        cell_valid <= 1;
        cell_value <= v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_cell(input int mode);
        case (mode)
            0: return 16'($signed($urandom_range(0, 3)) - 2);
            1: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_frame(input int r, input int c, input bit no_gap);
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < r * c; i++) send_cell(rand_cell(mode), no_gap);
    endtask

    initial begin
        int sent, r, c;
        rst_n = 0; cell_valid = 0; cell_value = '0; cfg_valid = 0; cfg_index = '0;
        cfg_data = '0; hold_out = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: 1x1 default frame, then extremes
        send_cell(16'sh8000, 0);
        set_frame(3, 3, 2, 2);
        send_cell(0, 0); send_cell(0, 0); send_cell(0, 0);
        send_cell(0, 0); send_cell(16'sh7fff, 0); send_cell(0, 0);
        send_cell(0, 0); send_cell(0, 0); send_cell(16'sh8000, 0);
        // flat frame: no peaks at all, ties everywhere
        for (int i = 0; i < 9; i++) send_cell(16'sh1234, 0);
        set_frame(1, 4, 1, 4);
        send_cell(1, 0); send_cell(-1, 0); send_cell(2, 0); send_cell(5, 0);
        // zero sizes count as one, target outside
        set_frame(0, 0, 2047, 0);
        send_cell(16'sh5555, 0);
        set_frame(2047, 2, 1, 1);
        send_cell(3, 0); send_cell(16'shaaaa, 0);
        set_frame(2, 1, 2, 1);
        send_cell(-7, 0); send_cell(-6, 0);
        // oversized width, then shrunk mid-row so the frame closes on the next cell
        set_frame(1, 2047, 1, 3);
        for (int i = 0; i < 6; i++) send_cell(rand_cell(2), 0);
        set_frame(1, 3, 1, 3);
        send_cell(rand_cell(2), 0);

        // long receiver hold-off while cells keep coming; alternating row peaks every other cell
        set_frame(1, 40, 1, 21);
        hold_out = 1;
        fork
            for (int i = 0; i < 40; i++) send_cell((i % 2 == 0) ? 16'sd100 : -16'sd100, 1);
            begin repeat (200) @(negedge clk); hold_out = 0; end
        join

        // random small frames
        sent = 0;
        while (sent < 155) begin
            r = $urandom_range(1, 5);
            c = $urandom_range(1, 6);
            set_frame(r, c, $urandom_range(0, r + 1), $urandom_range(0, c + 1));
            send_frame(r, c, 0);
            sent += r * c;
        end
        drain_out();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> grid_strict_local_peak_finder_top.f
src/gslpf_pkg.sv
src/gslpf_front.sv
src/gslpf_queue.sv
src/gslpf_back.sv
src/grid_strict_local_peak_finder_top.sv
sim/grid_strict_local_peak_finder_checker.sv
sim/grid_strict_local_peak_finder_top_tb.sv
